/* sv/fpla_pkg.sv */
// Shared types and constants for the fork pair lock arbiter
`default_nettype none
package fpla_pkg;

    localparam int ID_W     = 5;
    localparam int RING_MIN = 2;
    localparam int RING_RST = 5;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_EVAL,
        S_OUT0,
        S_OUT1
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_read;
        logic scan_eval;
        logic scan_finish;
        logic out_sel;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic       id_ok;
        logic       is_release;
        logic       pair_ok;
        logic       scan_done;
        logic [1:0] gcnt;
    } status_t;

endpackage
`default_nettype wire

/* sv/fpla_req_if.sv */
// Request/release channel: kind and requester id
`default_nettype none
interface fpla_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [fpla_pkg::ID_W-1:0] requester;

    modport source (output valid, output kind, output requester, input ready);
    modport sink   (input valid, input kind, input requester, output ready);
endinterface
`default_nettype wire

/* sv/fpla_grant_if.sv */
// Grant channel: granted id and last-of-burst flag
`default_nettype none
interface fpla_grant_if;
    logic                      valid;
    logic                      ready;
    logic [fpla_pkg::ID_W-1:0] granted;
    logic                      last;

    modport source (output valid, output granted, output last, input ready);
    modport sink   (input valid, input granted, input last, output ready);
endinterface
`default_nettype wire

/* sv/fpla_datapath.sv */
// Datapath: fork flags, wait list memory, scan counters and grant slots
`default_nettype none
module fpla_datapath #(
    parameter int MAX_PHILOSOPHERS = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_wr_en,
    input  wire  [fpla_pkg::ID_W-1:0]      cfg_wr_data,
    input  wire                            in_kind,
    input  wire  [fpla_pkg::ID_W-1:0]      in_requester,
    input  fpla_pkg::cmd_t                 cmd,
    output fpla_pkg::status_t              status,
    output logic [fpla_pkg::ID_W-1:0]      out_granted,
    output logic                           out_last
);

    localparam int AW    = $clog2(MAX_PHILOSOPHERS);
    localparam int CNT_W = $clog2(MAX_PHILOSOPHERS + 1);
    localparam int IW    = fpla_pkg::ID_W;
    localparam logic [IW-1:0] RING_RST_V =
        IW'((MAX_PHILOSOPHERS < fpla_pkg::RING_RST) ? MAX_PHILOSOPHERS : fpla_pkg::RING_RST);

    logic [MAX_PHILOSOPHERS-1:0] fork_free_reg, fork_free_next;
    logic [IW-1:0]               nring_reg, nring_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            keep_reg, keep_next;
    logic [1:0]                  gcnt_reg, gcnt_next;
    logic                        kind_reg, kind_next;
    logic [IW-1:0]               id_reg, id_next;
    logic [IW-1:0]               slot0_reg, slot0_next;
    logic [IW-1:0]               slot1_reg, slot1_next;
    logic [IW-1:0]               rd_data_reg;

    logic [IW-1:0]               wait_mem [MAX_PHILOSOPHERS];
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [IW-1:0]               mem_wdata;

    logic [IW-1:0]               cfg_ring;
    logic [AW-1:0]               in_left, in_right, w_left, w_right;
    logic                        in_ok, in_pair_free, w_ok;

    // clamp written ring size into 2..MAX
    always_comb
    begin
        if (cfg_wr_data < IW'(fpla_pkg::RING_MIN))
            cfg_ring = IW'(fpla_pkg::RING_MIN);
        else if (int'(cfg_wr_data) > MAX_PHILOSOPHERS)
            cfg_ring = IW'(MAX_PHILOSOPHERS);
        else
            cfg_ring = cfg_wr_data;
    end

    // fork p-1 on the left, fork p mod n on the right
    assign in_left      = AW'(id_reg - IW'(1));
    assign in_right     = (id_reg == nring_reg) ? '0 : AW'(id_reg);
    assign w_left       = AW'(rd_data_reg - IW'(1));
    assign w_right      = (rd_data_reg == nring_reg) ? '0 : AW'(rd_data_reg);

    assign in_ok        = (id_reg != '0) && (id_reg <= nring_reg);
    assign in_pair_free = fork_free_reg[in_left] && fork_free_reg[in_right];
    assign w_ok         = (rd_data_reg != '0) && (rd_data_reg <= nring_reg) &&
                          (gcnt_reg < 2'd2) &&
                          fork_free_reg[w_left] && fork_free_reg[w_right];

    assign status.id_ok      = in_ok;
    assign status.is_release = (kind_reg == fpla_pkg::KIND_RELEASE);
    assign status.pair_ok    = in_pair_free;
    assign status.scan_done  = (idx_reg == count_reg);
    assign status.gcnt       = gcnt_reg;

    assign out_granted = cmd.out_sel ? slot1_reg : slot0_reg;
    assign out_last    = cmd.out_last;

    always_comb
    begin
        fork_free_next = fork_free_reg;
        nring_next     = nring_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        gcnt_next      = gcnt_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        slot0_next     = slot0_reg;
        slot1_next     = slot1_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = id_reg;

        if (cfg_wr_en)
        begin
            nring_next     = cfg_ring;
            fork_free_next = '1;
            count_next     = '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                kind_next = in_kind;
                id_next   = in_requester;
            end

            if (cmd.exec && in_ok)
            begin
                if (kind_reg == fpla_pkg::KIND_RELEASE)
                begin
                    fork_free_next[in_left]  = 1'b1;
                    fork_free_next[in_right] = 1'b1;
                    idx_next                 = '0;
                    keep_next                = '0;
                    gcnt_next                = '0;
                end
                else if (in_pair_free)
                begin
                    fork_free_next[in_left]  = 1'b0;
                    fork_free_next[in_right] = 1'b0;
                    slot0_next               = id_reg;
                    gcnt_next                = 2'd1;
                end
                else if (count_reg < CNT_W'(MAX_PHILOSOPHERS))
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end

            if (cmd.scan_eval)
            begin
                if (w_ok)
                begin
                    fork_free_next[w_left]  = 1'b0;
                    fork_free_next[w_right] = 1'b0;
                    if (gcnt_reg == 2'd0)
                        slot0_next = rd_data_reg;
                    else
                        slot1_next = rd_data_reg;
                    gcnt_next = gcnt_reg + 2'd1;
                end
                else
                begin
                    // compact: survivor moves down to the keep position
                    mem_we    = 1'b1;
                    mem_waddr = keep_reg[AW-1:0];
                    mem_wdata = rd_data_reg;
                    keep_next = keep_reg + CNT_W'(1);
                end
                idx_next = idx_reg + CNT_W'(1);
            end

            if (cmd.scan_finish)
                count_next = keep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fork_free_reg <= '1;
            nring_reg     <= RING_RST_V;
            count_reg     <= '0;
            idx_reg       <= '0;
            keep_reg      <= '0;
            gcnt_reg      <= '0;
        end
        else
        begin
            fork_free_reg <= fork_free_next;
            nring_reg     <= nring_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            keep_reg      <= keep_next;
            gcnt_reg      <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            wait_mem[mem_waddr] <= mem_wdata;
        if (cmd.scan_read)
            rd_data_reg <= wait_mem[idx_reg[AW-1:0]];
    end

endmodule
`default_nettype wire

/* sv/fpla_ctrl.sv */
// Controller: sequences decode, wait list scan and grant output
`default_nettype none
module fpla_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    input  fpla_pkg::status_t  status,
    output fpla_pkg::cmd_t     cmd
);

    fpla_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpla_pkg::S_IDLE:
                if (in_valid)
                    state_next = fpla_pkg::S_EXEC;
            fpla_pkg::S_EXEC:
                if (!status.id_ok)
                    state_next = fpla_pkg::S_IDLE;
                else if (status.is_release)
                    state_next = fpla_pkg::S_READ;
                else if (status.pair_ok)
                    state_next = fpla_pkg::S_OUT0;
                else
                    state_next = fpla_pkg::S_IDLE;
            fpla_pkg::S_READ:
                if (!status.scan_done)
                    state_next = fpla_pkg::S_EVAL;
                else if (status.gcnt != 2'd0)
                    state_next = fpla_pkg::S_OUT0;
                else
                    state_next = fpla_pkg::S_IDLE;
            fpla_pkg::S_EVAL:
                state_next = fpla_pkg::S_READ;
            fpla_pkg::S_OUT0:
                if (out_ready)
                    state_next = (status.gcnt == 2'd2) ? fpla_pkg::S_OUT1 : fpla_pkg::S_IDLE;
            fpla_pkg::S_OUT1:
                if (out_ready)
                    state_next = fpla_pkg::S_IDLE;
            default:
                state_next = fpla_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            fpla_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            fpla_pkg::S_EXEC:
                cmd.exec = 1'b1;
            fpla_pkg::S_READ:
            begin
                cmd.scan_read   = !status.scan_done;
                cmd.scan_finish = status.scan_done;
            end
            fpla_pkg::S_EVAL:
                cmd.scan_eval = 1'b1;
            fpla_pkg::S_OUT0:
            begin
                out_valid    = 1'b1;
                cmd.out_last = (status.gcnt == 2'd1);
            end
            fpla_pkg::S_OUT1:
            begin
                out_valid    = 1'b1;
                cmd.out_sel  = 1'b1;
                cmd.out_last = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpla_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* sv/fork_pair_lock_arbiter.sv */
// Top level: fork pair lock arbiter for a ring of requesters
//
//  channel    dir  signals                         meaning
//  req        in   valid ready kind requester      kind 0 request, 1 release
//  grant      out  valid ready granted last        one item per grant, last ends burst
//  cfg        in   cfg_wr_en cfg_wr_data           ring size, clears forks and wait list
//
//  One item in flight. Request: accept, decode, then the grant item if its forks
//  are free. Release: accept, decode, then per queued entry a registered read of
//  the wait list memory and an evaluate/compact step, a final read state to close
//  the scan, then up to two grant items.
//  Reset: all forks free, wait list empty, ring size 5; no clearing pass.
//  A stalled grant holds its item; req is not taken until all grants are gone.
`default_nettype none
module fork_pair_lock_arbiter #(
    parameter int MAX_PHILOSOPHERS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_wr_en,
    input  wire [fpla_pkg::ID_W-1:0]  cfg_wr_data,
    fpla_req_if.sink                  req,
    fpla_grant_if.source              grant
);

    fpla_pkg::cmd_t              cmd;
    fpla_pkg::status_t           status;
    logic                        in_ready;
    logic                        out_valid;
    logic [fpla_pkg::ID_W-1:0]   out_granted;
    logic                        out_last;

    fpla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (grant.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fpla_datapath #(
        .MAX_PHILOSOPHERS (MAX_PHILOSOPHERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_kind      (req.kind),
        .in_requester (req.requester),
        .cmd          (cmd),
        .status       (status),
        .out_granted  (out_granted),
        .out_last     (out_last)
    );

    assign req.ready     = in_ready;
    assign grant.valid   = out_valid;
    assign grant.granted = out_granted;
    assign grant.last    = out_last;

endmodule
`default_nettype wire

/* sv/fpla_checker.sv */
// Port-level checker for the arbiter, bound to the top level
`default_nettype none
module fpla_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       in_ready,
    input wire                       out_valid,
    input wire                       out_ready,
    input wire [fpla_pkg::ID_W-1:0]  out_granted,
    input wire                       out_last
);

    // no new item is taken while grants of the current one are pending
    a_no_accept_during_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while a grant is pending");

    a_grant_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_granted != '0))
        else $error("grant of requester id zero");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> !out_valid)
        else $error("grant after the last of a burst");

    // at most two grants: a non-final one is followed at once by the final one
    a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> (out_valid && out_last))
        else $error("non-final grant not followed by the final grant");

    a_grant_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_granted) && $stable(out_last)))
        else $error("stalled grant item changed");

endmodule

bind fork_pair_lock_arbiter fpla_checker u_fpla_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (req.ready),
    .out_valid   (grant.valid),
    .out_ready   (grant.ready),
    .out_granted (grant.granted),
    .out_last    (grant.last)
);
`default_nettype wire

/* test/fork_pair_lock_arbiter_test.sv */
// Testbench for the fork pair lock arbiter: table-driven and random items against a grant predictor
`timescale 1ns / 100ps
module fork_pair_lock_arbiter_test;

    localparam int ID_W        = fpla_pkg::ID_W;
    localparam int MAX_PHIL    = 16;
    localparam int SCAN_CYCLES = 2 * MAX_PHIL + 3;
    localparam int SETTLE      = 2 * SCAN_CYCLES;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 180;
    localparam int IDLE_PCT    = 22;

    typedef struct packed {
        logic [ID_W-1:0] granted;
        logic            last;
    } grant_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t       what;
        logic            kind;
        logic [ID_W-1:0] value;
        logic            typed;
        logic [1:0]      n_due;
        grant_t          g0;
        grant_t          g1;
    } row_t;

    localparam grant_t NONE = '0;

    // value is the requester for items, the ring size for register writes
    localparam row_t DIRECTED [27] = '{
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd1,  1'b1, 2'd1, '{5'd1, 1'b1}, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd2,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd5,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd3,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd1,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd3,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd0,  1'b1, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd31, 1'b1, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd4,  1'b0, 2'd0, NONE, NONE},
        '{ROW_CFG,  fpla_pkg::KIND_REQUEST, 5'd16, 1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd2,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd4,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd1,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd5,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd3,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd2,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd4,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd16, 1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd1,  1'b1, 2'd1, '{5'd16, 1'b1}, NONE},
        '{ROW_CFG,  fpla_pkg::KIND_REQUEST, 5'd0,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd2,  1'b1, 2'd1, '{5'd2, 1'b1}, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd1,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd1,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd2,  1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_RELEASE, 5'd1,  1'b0, 2'd0, NONE, NONE},
        '{ROW_CFG,  fpla_pkg::KIND_REQUEST, 5'd31, 1'b0, 2'd0, NONE, NONE},
        '{ROW_ITEM, fpla_pkg::KIND_REQUEST, 5'd17, 1'b1, 2'd0, NONE, NONE}
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [ID_W-1:0] cfg_wr_data;

    fpla_req_if   req_ch ();
    fpla_grant_if grant_ch ();

    fork_pair_lock_arbiter #(.MAX_PHILOSOPHERS(MAX_PHIL)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch.sink),
        .grant       (grant_ch.source)
    );

    // predictor state
    logic [ID_W-1:0] ring_raw;
    logic            fork_free [MAX_PHIL];
    logic            holding [MAX_PHIL+1];
    logic [ID_W-1:0] waiters [$];
    grant_t          grants_due [$];
    int              errors = 0;
    bit              calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic int ring_size();
        int n;
        n = ring_raw;
        if (n < fpla_pkg::RING_MIN) n = fpla_pkg::RING_MIN;
        if (n > MAX_PHIL) n = MAX_PHIL;
        return n;
    endfunction

    function automatic logic pair_free(int p, int n);
        return fork_free[p-1] && fork_free[p % n];
    endfunction

    function automatic void set_pair(int p, int n, logic v);
        fork_free[p-1] = v;
        fork_free[p % n] = v;
    endfunction

    function automatic void clear_arbiter();
        foreach (fork_free[i]) fork_free[i] = 1'b1;
        foreach (holding[i]) holding[i] = 1'b0;
        waiters.delete();
    endfunction

    function automatic void predict_grants(input logic kind, input logic [ID_W-1:0] id,
                                           output grant_t res [2], output int cnt);
        int              n;
        logic [ID_W-1:0] kept [$];
        n = ring_size();
        cnt = 0;
        res[0] = '0;
        res[1] = '0;
        if (id < 1 || id > n) return;
        if (kind == fpla_pkg::KIND_REQUEST)
        begin
            if (pair_free(id, n))
            begin
                set_pair(id, n, 1'b0);
                holding[id] = 1'b1;
                res[0] = '{id, 1'b1};
                cnt = 1;
            end
            else if (waiters.size() < MAX_PHIL)
            begin
                waiters = {waiters, id};
            end
            return;
        end
        set_pair(id, n, 1'b1);
        holding[id] = 1'b0;
        // oldest first, at most two grants, the rest keep their order
        foreach (waiters[i])
        begin
            if (cnt < 2 && pair_free(waiters[i], n))
            begin
                set_pair(waiters[i], n, 1'b0);
                holding[waiters[i]] = 1'b1;
                res[cnt] = '{waiters[i], 1'b0};
                cnt++;
            end
            else
            begin
                kept = {kept, waiters[i]};
            end
        end
        waiters = kept;
        if (cnt > 0) res[cnt-1].last = 1'b1;
    endfunction

    // drive one item, wait for acceptance, then record what it grants
    task automatic issue(input logic kind, input logic [ID_W-1:0] id, input logic typed,
                         input int n_due, input grant_t g0, input grant_t g1);
        grant_t res [2];
        int     cnt;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.requester <= id;
        do @(posedge clk); while (!req_ch.ready);
        predict_grants(kind, id, res, cnt);
        if (typed)
        begin
            res[0] = g0;
            res[1] = g1;
            cnt = n_due;
        end
        for (int k = 0; k < cnt; k++) grants_due = {grants_due, res[k]};
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (grants_due.size() != 0);
    endtask

    // a queued request leaves nothing to wait for, so let any scan finish too
    task automatic write_ring(input logic [ID_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ring_raw = v;
        clear_arbiter();
    endtask

    // mostly requests and releases by holders; some stray releases and noise
    task automatic random_item(output logic in_range);
        int              n;
        int              sel;
        logic            kind;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] held [$];
        n = ring_size();
        for (int p = 1; p <= n; p++) if (holding[p]) held = {held, ID_W'(p)};
        sel  = $urandom_range(99);
        kind = fpla_pkg::KIND_REQUEST;
        id   = ID_W'($urandom_range(n, 1));
        if (sel < 8)
        begin
            kind = 1'($urandom_range(1));
            id   = ID_W'($urandom_range(31));
        end
        else if (sel >= 50 && sel < 85 && held.size() > 0)
        begin
            kind = fpla_pkg::KIND_RELEASE;
            id   = held[$urandom_range(held.size() - 1)];
        end
        else if (sel >= 85)
        begin
            kind = fpla_pkg::KIND_RELEASE;
        end
        in_range = (id >= 1 && id <= n);
        issue(kind, id, 1'b0, 0, NONE, NONE);
    endtask

    initial
    begin
        grant_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            grant_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        grant_t due;
        if (rst_n && grant_ch.valid && grant_ch.ready)
        begin
            if (grants_due.size() == 0)
            begin
                $error("unexpected grant item: granted %0d last %0b",
                       grant_ch.granted, grant_ch.last);
                errors++;
            end
            else
            begin
                due = grants_due.pop_front();
                if (grant_ch.granted !== due.granted)
                begin
                    $error("granted: expected %0d, actual %0d", due.granted, grant_ch.granted);
                    errors++;
                end
                if (grant_ch.last !== due.last)
                begin
                    $error("last: expected %0b, actual %0b", due.last, grant_ch.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic            in_range;
        int              done;
        logic [ID_W-1:0] ring_plan [PHASES];
        ring_plan = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd9};
        ring_plan[PHASES-1] = ID_W'($urandom_range(31));
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = fpla_pkg::KIND_REQUEST;
        req_ch.requester = '0;
        ring_raw         = ID_W'(fpla_pkg::RING_RST);
        clear_arbiter();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < $size(DIRECTED); r++)
        begin
            if (DIRECTED[r].what == ROW_CFG)
                write_ring(DIRECTED[r].value);
            else
                issue(DIRECTED[r].kind, DIRECTED[r].value, DIRECTED[r].typed,
                      DIRECTED[r].n_due, DIRECTED[r].g0, DIRECTED[r].g1);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_ring(ring_plan[ph]);
            calm = (ph == 2);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                // hold the sender back once until every grant is out
                if (ph == 4 && done == PHASE_ITEMS / 2) wait_drained();
                random_item(in_range);
                if (in_range) done++;
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* fork_pair_lock_arbiter.f */
sv/fpla_pkg.sv
sv/fpla_req_if.sv
sv/fpla_grant_if.sv
sv/fpla_datapath.sv
sv/fpla_ctrl.sv
sv/fork_pair_lock_arbiter.sv
sv/fpla_checker.sv
test/fork_pair_lock_arbiter_test.sv
